// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL files of the list unit.
// No dependencies; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ilsort_pkg.sv =====
// Package of the indexed list unit: field widths, operation and status codes,
// and the stored entry layout. No dependencies.
package ilsort_pkg;

    localparam int MODE_W   = 3;
    localparam int POS_W    = 6;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_GET    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SET    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SORT   = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REFUSED   = 2'd3;

    // One stored entry: fill flag over the value
    typedef struct packed {
        logic              present;
        logic [DATA_W-1:0] value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== rtl/core/ilsort_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used by the list unit for its entry storage.
module ilsort_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port, read port with old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/indexed_list_with_sort_unit.sv =====
// Top level of the indexed list unit: request decode, shift/sort sequencer,
// result register. Depends on ilsort_pkg, ilsort_ram and assert_macros.svh.
//
// Input channel (i_in_valid / o_in_ready) carries one request: mode, position
// and value. Output channel (o_out_valid / i_out_ready) returns one result per
// request: read value, present flag, entry count after the request, status.
// One request is worked at a time; o_in_ready is high only while idle, even
// while a finished result still waits in the output register.
// Get reads its entry from the RAM; set, append, insert at end, remove of the
// last entry and a failed request finish without a walk over the list.
// Insert inside the list moves the tail up entry by entry, top entry first;
// insert past the end pads the gap with empty entries before the new value.
// Remove inside the list moves the tail down entry by entry.
// Sort first checks that every entry is filled, stopping at an empty one,
// then runs bubble passes, each one entry shorter than the last, at most
// count - 1 passes, stopping early on a pass with no swap.
// Data moves through one RAM write and one read port a cycle; the sort uses a
// single signed comparator against a held element.
// Reset empties the list at once; no clearing pass. A stalled receiver holds
// the result in the output register and the next result waits behind it.
`include "assert_macros.svh"

module indexed_list_with_sort_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [ilsort_pkg::MODE_W-1:0]      i_mode,
    input  logic [ilsort_pkg::POS_W-1:0]       i_position,
    input  logic signed [ilsort_pkg::DATA_W-1:0] i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [ilsort_pkg::DATA_W-1:0] o_read_value,
    output logic                               o_present,
    output logic [ilsort_pkg::COUNT_W-1:0]     o_count,
    output logic [ilsort_pkg::STATUS_W-1:0]    o_status
);

    import ilsort_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int OW    = CW + COUNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_GET, S_PAD, S_SHUP, S_SHDN, S_SCAN, S_PLOAD, S_PASS, S_PEND, S_OUT
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_pos, n_pos;
    logic [CW-1:0]       r_last, n_last;
    logic [DATA_W-1:0]   r_val, n_val;
    logic [DATA_W-1:0]   r_hold, n_hold;
    logic                r_swapped, n_swapped;
    logic [DATA_W-1:0]   r_res_value, n_res_value;
    logic                r_res_present, n_res_present;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_value, n_out_value;
    logic                r_out_present, n_out_present;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;
    logic [STATUS_W-1:0] r_out_status, n_out_status;

    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    t_entry              ram_wr_data;
    logic [AW-1:0]       ram_rd_addr;
    logic [ENTRY_W-1:0]  ram_rd_data;
    t_entry              rd_q;

    logic [CMP_W-1:0]    pos_ext, pos_p1, cnt_ext, cap_c;
    logic [AW-1:0]       pos_addr, pos_p1_addr;
    logic                in_range, pos_fits, is_full;
    logic [CW-1:0]       cnt_p1, cnt_m1, idx_p1, idx_p2, idx_m1, idx_m2;
    logic [OW-1:0]       cnt_wide;
    logic                cmp_less;

    // Entry storage
    ilsort_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign rd_q = t_entry'(ram_rd_data);

    // Index arithmetic and range checks
    assign pos_ext     = CMP_W'(i_position);
    assign cnt_ext     = CMP_W'(r_count);
    assign cap_c       = CMP_W'(CAPACITY);
    assign pos_p1      = pos_ext + CMP_W'(1);
    assign pos_addr    = pos_ext[AW-1:0];
    assign pos_p1_addr = pos_p1[AW-1:0];
    assign in_range    = (pos_ext < cnt_ext);
    assign pos_fits    = (pos_ext < cap_c);
    assign is_full     = (cnt_ext >= cap_c);
    assign cnt_p1      = r_count + CW'(1);
    assign cnt_m1      = r_count - CW'(1);
    assign idx_p1      = r_idx + CW'(1);
    assign idx_p2      = r_idx + CW'(2);
    assign idx_m1      = r_idx - CW'(1);
    assign idx_m2      = r_idx - CW'(2);
    assign cnt_wide    = OW'(r_count);

    // Shared signed comparator for the sort passes
    assign cmp_less = ($signed(rd_q.value) < $signed(r_hold));

    // Sequencer next state
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_pos         = r_pos;
        n_last        = r_last;
        n_val         = r_val;
        n_hold        = r_hold;
        n_swapped     = r_swapped;
        n_res_value   = r_res_value;
        n_res_present = r_res_present;
        n_res_status  = r_res_status;
        n_out_valid   = r_out_valid;
        n_out_value   = r_out_value;
        n_out_present = r_out_present;
        n_out_count   = r_out_count;
        n_out_status  = r_out_status;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = r_idx[AW-1:0];
        ram_wr_data   = '0;
        ram_rd_addr   = r_idx[AW-1:0];

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pos         = pos_ext[CW-1:0];
                    n_val         = i_value;
                    n_res_value   = '0;
                    n_res_present = 1'b0;
                    n_res_status  = ST_OK;
                    n_state       = S_OUT;
                    case (i_mode)
                        MODE_GET: begin
                            if (!in_range) begin
                                n_res_status = ST_BAD_INDEX;
                            end else begin
                                ram_rd_addr = pos_addr;
                                n_state     = S_GET;
                            end
                        end
                        MODE_SET: begin
                            if (!in_range) begin
                                n_res_status = ST_BAD_INDEX;
                            end else begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = pos_addr;
                                ram_wr_data = '{present: 1'b1, value: i_value};
                            end
                        end
                        MODE_INSERT: begin
                            if (!pos_fits) begin
                                n_res_status = ST_BAD_INDEX;
                            end else if (pos_ext > cnt_ext) begin
                                // pad the gap with empty entries
                                n_idx   = r_count;
                                n_count = pos_p1[CW-1:0];
                                n_state = S_PAD;
                            end else if (is_full) begin
                                n_res_status = ST_FULL;
                            end else if (pos_ext == cnt_ext) begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = pos_addr;
                                ram_wr_data = '{present: 1'b1, value: i_value};
                                n_count     = cnt_p1;
                            end else begin
                                // move the tail up, top entry first
                                ram_rd_addr = cnt_m1[AW-1:0];
                                n_idx       = r_count;
                                n_count     = cnt_p1;
                                n_state     = S_SHUP;
                            end
                        end
                        MODE_REMOVE: begin
                            if (!in_range) begin
                                n_res_status = ST_BAD_INDEX;
                            end else begin
                                n_count = cnt_m1;
                                if (pos_p1 != cnt_ext) begin
                                    ram_rd_addr = pos_p1_addr;
                                    n_idx       = pos_ext[CW-1:0];
                                    n_state     = S_SHDN;
                                end
                            end
                        end
                        MODE_APPEND: begin
                            if (is_full) begin
                                n_res_status = ST_FULL;
                            end else begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = r_count[AW-1:0];
                                ram_wr_data = '{present: 1'b1, value: i_value};
                                n_count     = cnt_p1;
                            end
                        end
                        MODE_SORT: begin
                            if (r_count != '0) begin
                                ram_rd_addr = '0;
                                n_idx       = '0;
                                n_state     = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Read data for a get
            S_GET: begin
                n_res_present = rd_q.present;
                n_res_value   = rd_q.present ? rd_q.value : '0;
                n_state       = S_OUT;
            end

            // Fill empties up to the position, then the new value
            S_PAD: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_idx[AW-1:0];
                if (r_idx == r_pos) begin
                    ram_wr_data = '{present: 1'b1, value: r_val};
                    n_state     = S_OUT;
                end else begin
                    ram_wr_data = '0;
                    n_idx       = idx_p1;
                end
            end

            // Shift up: entry idx-1 lands at idx, then the new value at position
            S_SHUP: begin
                ram_wr_en = 1'b1;
                if (r_idx == r_pos) begin
                    ram_wr_addr = r_pos[AW-1:0];
                    ram_wr_data = '{present: 1'b1, value: r_val};
                    n_state     = S_OUT;
                end else begin
                    ram_wr_addr = r_idx[AW-1:0];
                    ram_wr_data = rd_q;
                    ram_rd_addr = idx_m2[AW-1:0];
                    n_idx       = idx_m1;
                end
            end

            // Shift down: entry idx+1 lands at idx
            S_SHDN: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_idx[AW-1:0];
                ram_wr_data = rd_q;
                if (idx_p1 == r_count) begin
                    n_state = S_OUT;
                end else begin
                    ram_rd_addr = idx_p2[AW-1:0];
                    n_idx       = idx_p1;
                end
            end

            // Check every entry is filled before sorting
            S_SCAN: begin
                if (!rd_q.present) begin
                    n_res_status = ST_REFUSED;
                    n_state      = S_OUT;
                end else if (idx_p1 == r_count) begin
                    if (r_count == CW'(1)) begin
                        n_state = S_OUT;
                    end else begin
                        n_last      = cnt_m1;
                        ram_rd_addr = '0;
                        n_state     = S_PLOAD;
                    end
                end else begin
                    ram_rd_addr = idx_p1[AW-1:0];
                    n_idx       = idx_p1;
                end
            end

            // Start of a bubble pass: hold entry 0
            S_PLOAD: begin
                n_hold      = rd_q.value;
                n_swapped   = 1'b0;
                ram_rd_addr = AW'(1);
                n_idx       = CW'(1);
                n_state     = S_PASS;
            end

            // Bubble step: smaller goes down, larger stays held
            S_PASS: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_m1[AW-1:0];
                if (cmp_less) begin
                    ram_wr_data = '{present: 1'b1, value: rd_q.value};
                    n_swapped   = 1'b1;
                end else begin
                    ram_wr_data = '{present: 1'b1, value: r_hold};
                    n_hold      = rd_q.value;
                end
                if (r_idx == r_last) begin
                    n_state = S_PEND;
                end else begin
                    ram_rd_addr = idx_p1[AW-1:0];
                    n_idx       = idx_p1;
                end
            end

            // End of pass: park the largest at the top
            S_PEND: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_last[AW-1:0];
                ram_wr_data = '{present: 1'b1, value: r_hold};
                if (!r_swapped || (r_last == CW'(1))) begin
                    n_state = S_OUT;
                end else begin
                    n_last      = r_last - CW'(1);
                    ram_rd_addr = '0;
                    n_state     = S_PLOAD;
                end
            end

            // Hand the result to the output register
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_value   = r_res_value;
                    n_out_present = r_res_present;
                    n_out_count   = cnt_wide[COUNT_W-1:0];
                    n_out_status  = r_res_status;
                    n_state       = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_pos         <= n_pos;
        r_last        <= n_last;
        r_val         <= n_val;
        r_hold        <= n_hold;
        r_swapped     <= n_swapped;
        r_res_value   <= n_res_value;
        r_res_present <= n_res_present;
        r_res_status  <= n_res_status;
        r_out_value   <= n_out_value;
        r_out_present <= n_out_present;
        r_out_count   <= n_out_count;
        r_out_status  <= n_out_status;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_present    = r_out_present;
    assign o_count      = r_out_count;
    assign o_status     = r_out_status;

    // Checks
    `ASSERT_HOLDS(a_count_bound, i_clk, i_rst_n, r_count <= CAPACITY, "count above capacity")
    `ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "ready after request")
    `ASSERT_IMPLIES(a_wr_addr_bound, i_clk, i_rst_n, ram_wr_en, ram_wr_addr < CAPACITY, "write past capacity")
    `ASSERT_IMPLIES(a_pass_bound, i_clk, i_rst_n, r_state == S_PASS, (r_idx <= r_last) && (r_last != '0), "pass index out of range")
    `ASSERT_IMPLIES(a_present_ok, i_clk, i_rst_n, o_out_valid && o_present, o_status == ST_OK, "present with error status")

endmodule
